// ===== rtl/time_sorted_unique_key_table_unit_assert.svh =====
// Assertion macros used by the table unit checker.
`ifndef TIME_SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH
`define TIME_SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSUKT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSUKT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tsukt_pkg.sv =====
// Shared constants, codes and types of the time sorted key table.
package tsukt_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int RANK_W = 7;
   localparam int CMD_W  = 2;
   localparam int ST_W   = 3;
   localparam int KH_W   = 16;
   localparam int KL_W   = 64;
   localparam int HR_W   = 5;
   localparam int MN_W   = 6;

   localparam logic [HR_W-1:0] HOUR_MAX   = HR_W'(23);
   localparam logic [MN_W-1:0] MINUTE_MAX = MN_W'(59);

   localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIST_ALL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIST_HOUR = 2'd3;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_KEY   = 3'd3;
   localparam logic [ST_W-1:0] ST_BAD_TIME  = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd6;
   localparam logic [ST_W-1:0] ST_NO_MATCH  = 3'd7;

   typedef struct packed {
      logic [KH_W-1:0] key_high;
      logic [KL_W-1:0] key_low;
      logic [HR_W-1:0] hour;
      logic [MN_W-1:0] minute;
   } entry_type;

   typedef struct packed {
      logic key_eq;
      logic time_le;
      logic hour_eq;
   } cmp_type;

endpackage

// ===== rtl/tsukt_cmp.sv =====
// Compare unit: one stored entry against the command's key and time.
module tsukt_cmp (
   input  tsukt_pkg::entry_type entry_i,
   input  tsukt_pkg::entry_type probe_i,
   output tsukt_pkg::cmp_type   result_o
);
   import tsukt_pkg::*;

   // minute < 64, so {hour, minute} orders the same as hour*60+minute for valid times
   assign result_o.key_eq  = (entry_i.key_high == probe_i.key_high) &&
                             (entry_i.key_low == probe_i.key_low);
   assign result_o.time_le = {entry_i.hour, entry_i.minute} <= {probe_i.hour, probe_i.minute};
   assign result_o.hour_eq = (entry_i.hour == probe_i.hour);

endmodule

// ===== rtl/time_sorted_unique_key_table_unit.sv =====
// Top level: time ordered table of unique keys with insert, delete and list commands.
//
// A command is taken when start is high and busy is low; busy then stays high at least
// until its last result has been driven. Results appear one per cycle on the rsp_ ports
// with rsp_strobe high for exactly one cycle and must be captured then: there is no back
// pressure. Entries live in a single-port-write, registered-read memory of DEPTH rows,
// and one compare unit looks at one row per cycle. A full list sends each row as it is
// read, and a list by hour holds each match back until the next match or a final flush
// step. A delete scans up to the match, answers, and then moves the rows behind it up
// one place with busy still high; nothing moves when it finds nothing or hits the last
// row. An insert scans all stored rows, which also covers the duplicate and time checks
// (a rejected insert answers at the end of the scan), then moves the later rows down one
// place before writing the new row. A full table or zero key insert, an insert with a bad
// time into an empty table, and a delete or list on an empty table answer in the next
// cycle with busy staying low; a good insert into an empty table goes straight to the
// write of the new row. No clearing pass is needed after reset.
module time_sorted_unique_key_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tsukt_pkg::CMD_W-1:0]  req_command,
   input  logic [tsukt_pkg::KH_W-1:0]   req_key_high,
   input  logic [tsukt_pkg::KL_W-1:0]   req_key_low,
   input  logic [tsukt_pkg::HR_W-1:0]   req_hour,
   input  logic [tsukt_pkg::MN_W-1:0]   req_minute,
   output logic                         rsp_strobe,
   output logic [tsukt_pkg::ST_W-1:0]   rsp_status,
   output logic [tsukt_pkg::RANK_W-1:0] rsp_rank,
   output logic [tsukt_pkg::KH_W-1:0]   rsp_out_key_high,
   output logic [tsukt_pkg::KL_W-1:0]   rsp_out_key_low,
   output logic [tsukt_pkg::HR_W-1:0]   rsp_out_hour,
   output logic [tsukt_pkg::MN_W-1:0]   rsp_out_minute,
   output logic                         rsp_last
);
   import tsukt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHUP  = 3'd2;
   localparam logic [2:0] S_SHDN  = 3'd3;
   localparam logic [2:0] S_PUT   = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   entry_type         probe_ff, probe_in;
   logic [IDX_W-1:0]  iss_ff, iss_in;
   logic              iss_on_ff, iss_on_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              dup_ff, dup_in;
   logic              pend_vld_ff, pend_vld_in;
   entry_type         pend_ff, pend_in;
   logic [RANK_W-1:0] pend_rank_ff, pend_rank_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   entry_type         rsp_ent_ff, rsp_ent_in;
   logic              rsp_last_ff, rsp_last_in;

   entry_type         tbl_mem [DEPTH];
   entry_type         rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   entry_type         mem_wd;
   logic [IDX_W-1:0]  mem_ra;

   cmp_type           cmp;
   logic              rd_last;
   logic [RANK_W-1:0] rd_rank;
   logic              req_key_zero;
   logic              req_time_bad;
   logic              probe_time_bad;

   tsukt_cmp u_cmp (
      .entry_i  (rd_data_ff),
      .probe_i  (probe_ff),
      .result_o (cmp)
   );

   assign rd_last        = ({1'b0, rd_idx_ff} + CNT_W'(1)) == cnt_ff;
   assign rd_rank        = RANK_W'(rd_idx_ff) + RANK_W'(1);
   assign req_key_zero   = (req_key_high == '0) && (req_key_low == '0);
   assign req_time_bad   = (req_hour > HOUR_MAX) || (req_minute > MINUTE_MAX);
   assign probe_time_bad = (probe_ff.hour > HOUR_MAX) || (probe_ff.minute > MINUTE_MAX);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      probe_in      = probe_ff;
      iss_in        = iss_ff;
      iss_on_in     = iss_on_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      pos_in        = pos_ff;
      dup_in        = dup_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      pend_rank_in  = pend_rank_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_rank_in   = '0;
      rsp_ent_in    = '0;
      rsp_last_in   = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = rd_idx_ff;
      mem_wd        = rd_data_ff;
      mem_ra        = iss_ff;

      // read issue; the row comes back in the next cycle tagged with rd_idx
      if (iss_on_ff && (state_ff == S_SCAN || state_ff == S_SHUP || state_ff == S_SHDN)) begin
         rd_vld_in = 1'b1;
         rd_idx_in = iss_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_command;
               probe_in    = '{key_high: req_key_high, key_low: req_key_low,
                               hour: req_hour, minute: req_minute};
               iss_in      = '0;
               iss_on_in   = 1'b0;
               pos_in      = '0;
               dup_in      = 1'b0;
               pend_vld_in = 1'b0;
               if (req_command == CMD_INSERT) begin
                  if (cnt_ff == CNT_W'(DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_last_in   = 1'b1;
                  end else if (req_key_zero) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_BAD_KEY;
                     rsp_last_in   = 1'b1;
                  end else if (cnt_ff == '0) begin
                     if (req_time_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BAD_TIME;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = S_PUT;
                     end
                  end else begin
                     state_in  = S_SCAN;
                     iss_on_in = 1'b1;
                  end
               end else if (cnt_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in  = S_SCAN;
                  iss_on_in = 1'b1;
               end
            end
         end

         S_SCAN: begin
            if (iss_on_ff) begin
               iss_in    = IDX_W'({1'b0, iss_ff} + CNT_W'(1));
               iss_on_in = ({1'b0, iss_ff} + CNT_W'(1)) < cnt_ff;
            end
            if (rd_vld_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (cmp.key_eq) begin
                        dup_in = 1'b1;
                     end
                     // table is sorted, so the insert point follows the last row not later
                     if (cmp.time_le) begin
                        pos_in = {1'b0, rd_idx_ff} + CNT_W'(1);
                     end
                     if (rd_last) begin
                        if (dup_in) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_DUPLICATE;
                           rsp_last_in   = 1'b1;
                           state_in      = S_IDLE;
                        end else if (probe_time_bad) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_BAD_TIME;
                           rsp_last_in   = 1'b1;
                           state_in      = S_IDLE;
                        end else if (pos_in == cnt_ff) begin
                           state_in = S_PUT;
                        end else begin
                           state_in  = S_SHUP;
                           iss_in    = IDX_W'(cnt_ff - CNT_W'(1));
                           iss_on_in = 1'b1;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (cmp.key_eq) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_ent_in    = rd_data_ff;
                        rsp_last_in   = 1'b1;
                        rd_vld_in     = 1'b0;
                        if (rd_last) begin
                           cnt_in    = cnt_ff - CNT_W'(1);
                           iss_on_in = 1'b0;
                           state_in  = S_IDLE;
                        end else begin
                           state_in  = S_SHDN;
                           iss_in    = IDX_W'({1'b0, rd_idx_ff} + CNT_W'(1));
                           iss_on_in = 1'b1;
                        end
                     end else if (rd_last) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_last_in   = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
                  CMD_LIST_ALL: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_rank_in   = rd_rank;
                     rsp_ent_in    = rd_data_ff;
                     rsp_last_in   = rd_last;
                     if (rd_last) begin
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     // hold one match back: only at the end is it known to be the last beat
                     if (cmp.hour_eq) begin
                        if (pend_vld_ff) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = ST_OK;
                           rsp_rank_in   = pend_rank_ff;
                           rsp_ent_in    = pend_ff;
                        end
                        pend_vld_in  = 1'b1;
                        pend_in      = rd_data_ff;
                        pend_rank_in = rd_rank;
                     end
                     if (rd_last) begin
                        state_in = S_FLUSH;
                     end
                  end
               endcase
            end
         end

         S_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            if (pend_vld_ff) begin
               rsp_status_in = ST_OK;
               rsp_rank_in   = pend_rank_ff;
               rsp_ent_in    = pend_ff;
            end else begin
               rsp_status_in = ST_NO_MATCH;
            end
            pend_vld_in = 1'b0;
            state_in    = S_IDLE;
         end

         S_SHUP: begin
            if (iss_on_ff) begin
               iss_in    = iss_ff - IDX_W'(1);
               iss_on_in = ({1'b0, iss_ff} != pos_ff);
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = IDX_W'({1'b0, rd_idx_ff} + CNT_W'(1));
               mem_wd = rd_data_ff;
               if ({1'b0, rd_idx_ff} == pos_ff) begin
                  state_in = S_PUT;
               end
            end
         end

         S_SHDN: begin
            if (iss_on_ff) begin
               iss_in    = IDX_W'({1'b0, iss_ff} + CNT_W'(1));
               iss_on_in = ({1'b0, iss_ff} + CNT_W'(1)) < cnt_ff;
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = rd_idx_ff - IDX_W'(1);
               mem_wd = rd_data_ff;
               if (rd_last) begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = S_IDLE;
               end
            end
         end

         S_PUT: begin
            mem_we        = 1'b1;
            mem_wa        = IDX_W'(pos_ff);
            mem_wd        = probe_ff;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_last_in   = 1'b1;
            iss_on_in     = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in  = S_IDLE;
            iss_on_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= tbl_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         iss_on_ff     <= 1'b0;
         rd_vld_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         iss_on_ff     <= iss_on_in;
         rd_vld_ff     <= rd_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      probe_ff      <= probe_in;
      iss_ff        <= iss_in;
      rd_idx_ff     <= rd_idx_in;
      pos_ff        <= pos_in;
      dup_ff        <= dup_in;
      pend_ff       <= pend_in;
      pend_rank_ff  <= pend_rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_out_key_high = rsp_ent_ff.key_high;
   assign rsp_out_key_low  = rsp_ent_ff.key_low;
   assign rsp_out_hour     = rsp_ent_ff.hour;
   assign rsp_out_minute   = rsp_ent_ff.minute;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/tsukt_chk.sv =====
// Port-level checker for the table unit, bound to the top level.
`include "time_sorted_unique_key_table_unit_assert.svh"

module tsukt_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [tsukt_pkg::ST_W-1:0]   rsp_status,
   input logic [tsukt_pkg::RANK_W-1:0] rsp_rank,
   input logic                         rsp_last
);
   import tsukt_pkg::*;

   // every accepted command either answers at once or goes busy
   `TSUKT_ASSERT_NEXT(a_accept_reacts, clock, reset, start && !busy, busy || rsp_strobe, "accepted command neither answered nor went busy")

   // more beats pending means the block must still look busy
   `TSUKT_ASSERT_SAME(a_more_beats_busy, clock, reset, rsp_strobe && !rsp_last, busy, "non-final beat while not busy")

   // error statuses are single, rankless beats
   `TSUKT_ASSERT_SAME(a_error_single, clock, reset, rsp_strobe && (rsp_status != ST_OK), rsp_last && (rsp_rank == '0), "error status with rank or not final")

   `TSUKT_ASSERT_SAME(a_rank_range, clock, reset, rsp_strobe, rsp_rank <= RANK_W'(DEPTH), "rank beyond table depth")

endmodule

bind time_sorted_unique_key_table_unit tsukt_chk u_tsukt_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_rank   (rsp_rank),
   .rsp_last   (rsp_last)
);
